FILE: hdl/hirt_pkg.sv
// shared types and constants of the held input release tracker
`timescale 1ns / 1ps

package hirt_pkg;

  localparam int CMD_W  = 2;
  localparam int POS_W  = 13;
  localparam int SCR_W  = 14;
  localparam int BTN_W  = 8;
  localparam int KEY_W  = 32;
  localparam int KIND_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CMD_W-1:0] CMD_POINTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_KEY     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POINTER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_KEY     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEARCH,
    ST_DECIDE,
    ST_MOVE,
    ST_EMIT,
    ST_REL_BTN,
    ST_REL_RD,
    ST_REL_OUT
  } state_t;

endpackage

FILE: hdl/hirt_in_if.sv
// command channel between a source and the tracker
`timescale 1ns / 1ps

interface hirt_in_if;
  logic                        valid;
  logic                        ready;
  logic [hirt_pkg::CMD_W-1:0]  command;
  logic [hirt_pkg::POS_W-1:0]  pos_x;
  logic [hirt_pkg::POS_W-1:0]  pos_y;
  logic [hirt_pkg::BTN_W-1:0]  button_mask;
  logic [hirt_pkg::KEY_W-1:0]  key_code;
  logic                        key_down;

  modport source (output valid, command, pos_x, pos_y, button_mask, key_code, key_down,
                  input ready);
  modport sink   (input valid, command, pos_x, pos_y, button_mask, key_code, key_down,
                  output ready);
endinterface

FILE: hdl/hirt_out_if.sv
// result channel from the tracker to its consumer
`timescale 1ns / 1ps

interface hirt_out_if;
  logic                        valid;
  logic                        ready;
  logic [hirt_pkg::KIND_W-1:0] event_kind;
  logic [hirt_pkg::POS_W-1:0]  out_x;
  logic [hirt_pkg::POS_W-1:0]  out_y;
  logic [hirt_pkg::BTN_W-1:0]  out_buttons;
  logic [hirt_pkg::KEY_W-1:0]  out_key;
  logic                        out_down;
  logic                        accepted;
  logic                        last;

  modport source (output valid, event_kind, out_x, out_y, out_buttons, out_key, out_down,
                  accepted, last, input ready);
  modport sink   (input valid, event_kind, out_x, out_y, out_buttons, out_key, out_down,
                  accepted, last, output ready);
endinterface

FILE: hdl/held_input_release_tracker_unit.sv
// top level of the held input release tracker
`timescale 1ns / 1ps

// Takes one command at a time and is not ready until its last result has been
// loaded into the output register; the next command may then enter while that
// result still waits. Held keys live in a table with one write port and one
// registered read port. A key command scans the table for the key, one entry
// per cycle, and a key-up of a held key passes through a move step that copies
// the last entry into the freed slot; a release-all first releases any held
// buttons, then reads out each held key in turn.
// Results stall in place while the consumer holds off ready.
module held_input_release_tracker_unit #(
  parameter int KEY_SLOTS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  hirt_in_if.sink                            in_ch,
  hirt_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [hirt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hirt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CW = $clog2(KEY_SLOTS + 1);

  // configuration
  logic                             en_r;
  logic [hirt_pkg::SCR_W-1:0]       width_r;
  logic [hirt_pkg::SCR_W-1:0]       height_r;

  // captured command
  logic [hirt_pkg::CMD_W-1:0]       cmd_r;
  logic [hirt_pkg::POS_W-1:0]       x_r;
  logic [hirt_pkg::POS_W-1:0]       y_r;
  logic [hirt_pkg::BTN_W-1:0]       btn_r;
  logic [hirt_pkg::KEY_W-1:0]       key_r;
  logic                             down_r;

  // tracker state
  hirt_pkg::state_t                 state_r, state_nxt;
  logic [CW-1:0]                    count_r, count_nxt;
  logic [hirt_pkg::POS_W-1:0]       last_x_r, last_x_nxt;
  logic [hirt_pkg::POS_W-1:0]       last_y_r, last_y_nxt;
  logic [hirt_pkg::BTN_W-1:0]       last_btn_r, last_btn_nxt;

  // sequencer registers
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic                             chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]                    chk_idx_r, chk_idx_nxt;
  logic                             found_r, found_nxt;
  logic [IW-1:0]                    found_idx_r, found_idx_nxt;
  logic [hirt_pkg::KIND_W-1:0]      res_kind_r, res_kind_nxt;
  logic                             res_acc_r, res_acc_nxt;

  // output register
  logic                             out_valid_r;
  logic [hirt_pkg::KIND_W-1:0]      o_kind_r;
  logic [hirt_pkg::POS_W-1:0]       o_x_r;
  logic [hirt_pkg::POS_W-1:0]       o_y_r;
  logic [hirt_pkg::BTN_W-1:0]       o_btn_r;
  logic [hirt_pkg::KEY_W-1:0]       o_key_r;
  logic                             o_down_r;
  logic                             o_acc_r;
  logic                             o_last_r;

  logic                             out_free;
  logic                             out_load;
  logic [hirt_pkg::KIND_W-1:0]      ld_kind;
  logic [hirt_pkg::POS_W-1:0]       ld_x;
  logic [hirt_pkg::POS_W-1:0]       ld_y;
  logic [hirt_pkg::BTN_W-1:0]       ld_btn;
  logic [hirt_pkg::KEY_W-1:0]       ld_key;
  logic                             ld_down;
  logic                             ld_acc;
  logic                             ld_last;

  // table port
  logic                             mem_we;
  logic [IW-1:0]                    mem_wa;
  logic [hirt_pkg::KEY_W-1:0]       mem_wd;
  logic [IW-1:0]                    mem_ra;
  logic [hirt_pkg::KEY_W-1:0]       mem_rd;

  logic                             in_fire;
  logic                             pos_ok;
  logic [CW-1:0]                    count_dec;
  logic [CW-1:0]                    cnt_inc;

  hirt_key_mem #(
    .KEY_SLOTS (KEY_SLOTS),
    .IW        (IW)
  ) u_key_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  assign in_ch.ready = (state_r == hirt_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign count_dec   = count_r - 1'b1;
  assign cnt_inc     = cnt_r + 1'b1;
  assign pos_ok      = en_r && ({1'b0, x_r} < width_r) && ({1'b0, y_r} < height_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r     <= 1'b0;
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hirt_pkg::CFG_ENABLE: en_r     <= cfg_data[0];
        hirt_pkg::CFG_WIDTH:  width_r  <= cfg_data;
        hirt_pkg::CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_ch.command;
      x_r    <= in_ch.pos_x;
      y_r    <= in_ch.pos_y;
      btn_r  <= in_ch.button_mask;
      key_r  <= in_ch.key_code;
      down_r <= in_ch.key_down;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hirt_pkg::ST_IDLE;
      count_r     <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_btn_r  <= '0;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      chk_idx_r   <= '0;
      found_r     <= 1'b0;
      found_idx_r <= '0;
      res_kind_r  <= hirt_pkg::KIND_NONE;
      res_acc_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      last_btn_r  <= last_btn_nxt;
      cnt_r       <= cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      chk_idx_r   <= chk_idx_nxt;
      found_r     <= found_nxt;
      found_idx_r <= found_idx_nxt;
      res_kind_r  <= res_kind_nxt;
      res_acc_r   <= res_acc_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_kind_r <= ld_kind;
      o_x_r    <= ld_x;
      o_y_r    <= ld_y;
      o_btn_r  <= ld_btn;
      o_key_r  <= ld_key;
      o_down_r <= ld_down;
      o_acc_r  <= ld_acc;
      o_last_r <= ld_last;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    last_btn_nxt  = last_btn_r;
    cnt_nxt       = cnt_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    res_kind_nxt  = res_kind_r;
    res_acc_nxt   = res_acc_r;
    mem_we        = 1'b0;
    mem_wa        = count_r[IW-1:0];
    mem_wd        = key_r;
    mem_ra        = cnt_r[IW-1:0];
    out_load      = 1'b0;
    ld_kind       = hirt_pkg::KIND_NONE;
    ld_x          = '0;
    ld_y          = '0;
    ld_btn        = '0;
    ld_key        = '0;
    ld_down       = 1'b0;
    ld_acc        = 1'b0;
    ld_last       = 1'b0;

    case (state_r)
      hirt_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = hirt_pkg::ST_DISPATCH;
        end
      end

      hirt_pkg::ST_DISPATCH: begin
        res_kind_nxt = hirt_pkg::KIND_NONE;
        res_acc_nxt  = 1'b0;
        state_nxt    = hirt_pkg::ST_EMIT;
        case (cmd_r)
          hirt_pkg::CMD_POINTER: begin
            if (pos_ok) begin
              last_x_nxt   = x_r;
              last_y_nxt   = y_r;
              last_btn_nxt = btn_r;
              res_kind_nxt = hirt_pkg::KIND_POINTER;
              res_acc_nxt  = 1'b1;
            end
          end
          hirt_pkg::CMD_KEY: begin
            if (en_r) begin
              cnt_nxt   = '0;
              found_nxt = 1'b0;
              state_nxt = hirt_pkg::ST_SEARCH;
            end
          end
          hirt_pkg::CMD_RELEASE: begin
            cnt_nxt   = '0;
            state_nxt = hirt_pkg::ST_REL_BTN;
          end
          default: ;
        endcase
      end

      // reads issue one a cycle, each compare follows in the next cycle
      hirt_pkg::ST_SEARCH: begin
        if (chk_vld_r && (mem_rd == key_r)) begin
          found_nxt     = 1'b1;
          found_idx_nxt = chk_idx_r;
        end
        if (cnt_r < count_r) begin
          mem_ra      = cnt_r[IW-1:0];
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = cnt_r[IW-1:0];
          cnt_nxt     = cnt_inc;
        end else if (!chk_vld_r) begin
          state_nxt = hirt_pkg::ST_DECIDE;
        end
      end

      hirt_pkg::ST_DECIDE: begin
        res_kind_nxt = hirt_pkg::KIND_KEY;
        res_acc_nxt  = 1'b1;
        state_nxt    = hirt_pkg::ST_EMIT;
        mem_ra       = count_dec[IW-1:0];
        if (down_r && !found_r) begin
          if (count_r >= CW'(KEY_SLOTS)) begin
            res_kind_nxt = hirt_pkg::KIND_NONE;
            res_acc_nxt  = 1'b0;
          end else begin
            mem_we    = 1'b1;
            mem_wa    = count_r[IW-1:0];
            mem_wd    = key_r;
            count_nxt = count_r + 1'b1;
          end
        end else if (!down_r && found_r) begin
          // last entry is being read, it fills the freed slot next cycle
          count_nxt = count_dec;
          state_nxt = hirt_pkg::ST_MOVE;
        end
      end

      hirt_pkg::ST_MOVE: begin
        mem_we    = 1'b1;
        mem_wa    = found_idx_r;
        mem_wd    = mem_rd;
        state_nxt = hirt_pkg::ST_EMIT;
      end

      hirt_pkg::ST_EMIT: begin
        ld_kind = res_kind_r;
        ld_acc  = res_acc_r;
        ld_last = 1'b1;
        if (res_kind_r == hirt_pkg::KIND_POINTER) begin
          ld_x   = x_r;
          ld_y   = y_r;
          ld_btn = btn_r;
        end
        if (res_kind_r == hirt_pkg::KIND_KEY) begin
          ld_key  = key_r;
          ld_down = down_r;
        end
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = hirt_pkg::ST_IDLE;
        end
      end

      hirt_pkg::ST_REL_BTN: begin
        ld_acc = 1'b1;
        if (last_btn_r != '0) begin
          ld_kind = hirt_pkg::KIND_POINTER;
          ld_x    = last_x_r;
          ld_y    = last_y_r;
          ld_last = (count_r == '0);
          if (out_free) begin
            out_load = 1'b1;
            if (count_r == '0) begin
              last_btn_nxt = '0;
              state_nxt    = hirt_pkg::ST_IDLE;
            end else begin
              state_nxt = hirt_pkg::ST_REL_RD;
            end
          end
        end else if (count_r == '0) begin
          // nothing held: a single empty accepted result
          ld_last = 1'b1;
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = hirt_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = hirt_pkg::ST_REL_RD;
        end
      end

      hirt_pkg::ST_REL_RD: begin
        mem_ra    = cnt_r[IW-1:0];
        state_nxt = hirt_pkg::ST_REL_OUT;
      end

      hirt_pkg::ST_REL_OUT: begin
        mem_ra  = cnt_r[IW-1:0];
        ld_kind = hirt_pkg::KIND_KEY;
        ld_key  = mem_rd;
        ld_acc  = 1'b1;
        ld_last = (cnt_inc == count_r);
        if (out_free) begin
          out_load = 1'b1;
          cnt_nxt  = cnt_inc;
          if (cnt_inc == count_r) begin
            last_btn_nxt = '0;
            count_nxt    = '0;
            state_nxt    = hirt_pkg::ST_IDLE;
          end else begin
            state_nxt = hirt_pkg::ST_REL_RD;
          end
        end
      end

      default: begin
        state_nxt = hirt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_kind  = o_kind_r;
  assign out_ch.out_x       = o_x_r;
  assign out_ch.out_y       = o_y_r;
  assign out_ch.out_buttons = o_btn_r;
  assign out_ch.out_key     = o_key_r;
  assign out_ch.out_down    = o_down_r;
  assign out_ch.accepted    = o_acc_r;
  assign out_ch.last        = o_last_r;

endmodule

FILE: hdl/hirt_key_mem.sv
// held key table: one write port, one registered read port
`timescale 1ns / 1ps

module hirt_key_mem #(
  parameter int KEY_SLOTS = 32,
  parameter int IW        = 5
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [IW-1:0]               wr_addr,
  input  logic [hirt_pkg::KEY_W-1:0]  wr_data,
  input  logic [IW-1:0]               rd_addr,
  output logic [hirt_pkg::KEY_W-1:0]  rd_data
);

  logic [hirt_pkg::KEY_W-1:0] mem [KEY_SLOTS];
  logic [hirt_pkg::KEY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
